/* hw/rtl/source_char_tokenizer_macros.svh */
// Assertion helpers for the source character tokenizer.
// Each macro takes a label, a property expression and a message.
`ifndef SOURCE_CHAR_TOKENIZER_MACROS_SVH
`define SOURCE_CHAR_TOKENIZER_MACROS_SVH
`ifndef SYNTHESIS
// Checked on every clock edge while reset is low
`define SCT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every clock edge, reset included
`define SCT_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SCT_ASSERT(lbl, prop, msg)
`define SCT_ASSERT_RST(lbl, prop, msg)
`endif
`endif

/* hw/rtl/sct_pkg.sv */
`timescale 1ns / 1ps

package sct_pkg;

  // Defaults for the top level parameters
  localparam int MAX_TOKEN_LEN_DEF = 255;
  localparam int LINE_BITS_DEF     = 16;

  // Result queue depth
  localparam int OQ_DEPTH = 4;

  // Pending token class
  typedef enum logic [1:0] {
    PC_NONE,
    PC_IDENT,
    PC_NUMBER,
    PC_PREFIX
  } pend_class_t;

  // Keyword still being matched
  typedef enum logic [1:0] {
    KW_NONE,
    KW_IF,
    KW_THEN,
    KW_ELSE
  } kw_t;

  // Token kinds
  localparam logic [2:0] KIND_INT   = 3'd0;
  localparam logic [2:0] KIND_OP    = 3'd1;
  localparam logic [2:0] KIND_PUNCT = 3'd2;
  localparam logic [2:0] KIND_COND  = 3'd3;
  localparam logic [2:0] KIND_IDENT = 3'd4;

  // Operator and punctuator codes
  localparam logic [4:0] SYM_ADD    = 5'd0;
  localparam logic [4:0] SYM_SUB    = 5'd1;
  localparam logic [4:0] SYM_MUL    = 5'd2;
  localparam logic [4:0] SYM_DIV    = 5'd3;
  localparam logic [4:0] SYM_ASSIGN = 5'd4;
  localparam logic [4:0] SYM_EQ     = 5'd5;
  localparam logic [4:0] SYM_NE     = 5'd6;
  localparam logic [4:0] SYM_LE     = 5'd7;
  localparam logic [4:0] SYM_GE     = 5'd8;
  localparam logic [4:0] SYM_LT     = 5'd9;
  localparam logic [4:0] SYM_GT     = 5'd10;
  localparam logic [4:0] SYM_MOD    = 5'd11;
  localparam logic [4:0] SYM_LPAREN = 5'd12;
  localparam logic [4:0] SYM_RPAREN = 5'd13;
  localparam logic [4:0] SYM_LBRACE = 5'd14;
  localparam logic [4:0] SYM_RBRACE = 5'd15;
  localparam logic [4:0] SYM_COMMA  = 5'd16;
  localparam logic [4:0] SYM_SEMI   = 5'd17;

  // Source bytes with a meaning of their own
  localparam logic [7:0] CH_NL      = 8'd10;
  localparam logic [7:0] CH_EQ      = "=";
  localparam logic [7:0] CH_LT      = "<";
  localparam logic [7:0] CH_GT      = ">";
  localparam logic [7:0] CH_BANG    = "!";
  localparam logic [7:0] CH_SLASH   = "/";
  localparam logic [7:0] CH_HASH    = "#";
  localparam logic [7:0] CH_PLUS    = "+";
  localparam logic [7:0] CH_MINUS   = "-";
  localparam logic [7:0] CH_STAR    = "*";
  localparam logic [7:0] CH_PERCENT = "%";
  localparam logic [7:0] CH_LPAREN  = "(";
  localparam logic [7:0] CH_RPAREN  = ")";
  localparam logic [7:0] CH_LBRACE  = "{";
  localparam logic [7:0] CH_RBRACE  = "}";
  localparam logic [7:0] CH_COMMA   = ",";
  localparam logic [7:0] CH_SEMI    = ";";

  // One result record
  typedef struct packed {
    logic [2:0]  kind;
    logic [4:0]  symbol;
    logic [15:0] line;
    logic [15:0] column;
    logic [7:0]  length;
    logic        last_of_run;
  } tok_t;

  function automatic logic is_alpha(logic [7:0] c);
    return (c inside {["a":"z"], ["A":"Z"]}) || (c == "_");
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c inside {["0":"9"]};
  endfunction

  // Keyword length in bytes
  function automatic logic [2:0] kw_len(kw_t k);
    logic [2:0] n;
    case (k)
      KW_IF:   n = 3'd2;
      KW_THEN: n = 3'd4;
      KW_ELSE: n = 3'd4;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  // Keyword byte at position p
  function automatic logic [7:0] kw_char(kw_t k, logic [1:0] p);
    logic [31:0] w;
    case (k)
      KW_IF:   w = {"if", 16'h0000};
      KW_THEN: w = "then";
      KW_ELSE: w = "else";
      default: w = 32'h0;
    endcase
    return w[{~p, 3'b000} +: 8];
  endfunction

endpackage

/* hw/rtl/sct_core.sv */
`timescale 1ns / 1ps

module sct_core #(
  parameter int MAX_TOKEN_LEN = 255,
  parameter int LINE_BITS     = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic [7:0]    ch,
  input  logic          end_of_text,
  output logic [1:0]    n_res,
  output sct_pkg::tok_t res0,
  output sct_pkg::tok_t res1
);

  import sct_pkg::*;

  localparam int TLW = $clog2(MAX_TOKEN_LEN + 1);
  localparam logic [LINE_BITS-1:0] CNT_MAX = '1;
  localparam logic [TLW-1:0]       LEN_MAX = TLW'(MAX_TOKEN_LEN);

  typedef struct packed {
    logic valid;
    tok_t tok;
  } cand_t;

  // Tokenizer state
  pend_class_t          pending_class, pending_class_next;
  logic [7:0]           pending_char, pending_char_next;
  logic                 skip_to_eol, skip_to_eol_next;
  logic [LINE_BITS-1:0] line_count, line_count_next;
  logic [LINE_BITS-1:0] column_count, column_count_next;
  logic [LINE_BITS-1:0] token_start, token_start_next;
  logic [TLW-1:0]       token_length, token_length_next;
  kw_t                  keyword_match, keyword_match_next;

  // Working values after the byte itself
  pend_class_t          m_class;
  logic [7:0]           m_char;
  logic                 m_skip;
  logic [LINE_BITS-1:0] m_line;
  logic [LINE_BITS-1:0] m_col;
  logic [LINE_BITS-1:0] m_start;
  logic [TLW-1:0]       m_len;
  kw_t                  m_kw;
  logic                 do_fresh;
  logic [LINE_BITS-1:0] col_inc;
  cand_t                old_flush;
  cand_t                ca, cb, cc;

  // Token record for whatever is pending
  function automatic cand_t flush_tok(pend_class_t pc, logic [7:0] pch, kw_t km,
                                      logic [TLW-1:0] tl, logic [LINE_BITS-1:0] ts,
                                      logic [LINE_BITS-1:0] ln);
    cand_t r;
    r = '0;
    r.tok.line   = 16'(ln);
    r.tok.column = 16'(ts);
    case (pc)
      PC_IDENT: begin
        r.valid      = 1'b1;
        r.tok.kind   = (km != KW_NONE && tl == TLW'(kw_len(km))) ? KIND_COND : KIND_IDENT;
        r.tok.length = 8'(tl);
      end
      PC_NUMBER: begin
        r.valid      = 1'b1;
        r.tok.kind   = KIND_INT;
        r.tok.length = 8'(tl);
      end
      PC_PREFIX: begin
        r.tok.kind   = KIND_OP;
        r.tok.length = 8'd1;
        case (pch)
          CH_EQ: begin
            r.valid = 1'b1;
            r.tok.symbol = SYM_ASSIGN;
          end
          CH_LT: begin
            r.valid = 1'b1;
            r.tok.symbol = SYM_LT;
          end
          CH_GT: begin
            r.valid = 1'b1;
            r.tok.symbol = SYM_GT;
          end
          CH_SLASH: begin
            r.valid = 1'b1;
            r.tok.symbol = SYM_DIV;
          end
          // a lone ! gives nothing
          default: r.valid = 1'b0;
        endcase
      end
      default: r.valid = 1'b0;
    endcase
    return r;
  endfunction

  assign col_inc   = (column_count < CNT_MAX) ? LINE_BITS'(column_count + 1'b1) : column_count;
  assign old_flush = flush_tok(pending_class, pending_char, keyword_match, token_length,
                               token_start, line_count);

  // Per-byte update: flush or extend, fresh token, then final flush
  always_comb begin
    m_class  = pending_class;
    m_char   = pending_char;
    m_skip   = skip_to_eol;
    m_line   = line_count;
    m_col    = column_count;
    m_start  = token_start;
    m_len    = token_length;
    m_kw     = keyword_match;
    do_fresh = 1'b0;
    ca       = '0;
    cb       = '0;

    if (ch == CH_NL) begin
      ca      = old_flush;
      m_class = PC_NONE;
      m_char  = 8'd0;
      m_len   = '0;
      m_kw    = KW_NONE;
      m_skip  = 1'b0;
      m_line  = (line_count < CNT_MAX) ? LINE_BITS'(line_count + 1'b1) : line_count;
      m_col   = '0;
    end else begin
      m_col = col_inc;
      if (skip_to_eol) begin
        // comment body
      end else if (pending_class == PC_PREFIX && ch == CH_EQ &&
                   (pending_char == CH_EQ || pending_char == CH_BANG ||
                    pending_char == CH_LT || pending_char == CH_GT)) begin
        ca.valid        = 1'b1;
        ca.tok.kind     = KIND_OP;
        ca.tok.line     = 16'(line_count);
        ca.tok.column   = 16'(token_start);
        ca.tok.length   = 8'd2;
        case (pending_char)
          CH_EQ:   ca.tok.symbol = SYM_EQ;
          CH_BANG: ca.tok.symbol = SYM_NE;
          CH_LT:   ca.tok.symbol = SYM_LE;
          default: ca.tok.symbol = SYM_GE;
        endcase
        m_class = PC_NONE;
        m_char  = 8'd0;
        m_len   = '0;
      end else if (pending_class == PC_PREFIX && ch == CH_SLASH &&
                   pending_char == CH_SLASH) begin
        m_class = PC_NONE;
        m_char  = 8'd0;
        m_len   = '0;
        m_skip  = 1'b1;
      end else if ((pending_class == PC_IDENT && (is_alpha(ch) || is_digit(ch))) ||
                   (pending_class == PC_NUMBER && is_digit(ch))) begin
        // extend, dropping a keyword candidate on the first mismatch
        if (keyword_match != KW_NONE &&
            (token_length >= TLW'(kw_len(keyword_match)) ||
             kw_char(keyword_match, token_length[1:0]) != ch)) begin
          m_kw = KW_NONE;
        end
        if (token_length < LEN_MAX) begin
          m_len = TLW'(token_length + 1'b1);
        end
      end else begin
        ca       = old_flush;
        m_class  = PC_NONE;
        m_char   = 8'd0;
        m_len    = '0;
        m_kw     = KW_NONE;
        do_fresh = 1'b1;
      end
    end

    // Byte that starts something new
    if (do_fresh) begin
      cb.tok.line   = 16'(line_count);
      cb.tok.column = 16'(col_inc);
      cb.tok.length = 8'd1;
      if (is_alpha(ch)) begin
        m_class = PC_IDENT;
        m_start = col_inc;
        m_len   = TLW'(1);
        m_kw    = (ch == "i") ? KW_IF : (ch == "t") ? KW_THEN : (ch == "e") ? KW_ELSE : KW_NONE;
      end else if (is_digit(ch)) begin
        m_class = PC_NUMBER;
        m_start = col_inc;
        m_len   = TLW'(1);
      end else if (ch == CH_EQ || ch == CH_LT || ch == CH_GT || ch == CH_BANG ||
                   ch == CH_SLASH) begin
        m_class = PC_PREFIX;
        m_char  = ch;
        m_start = col_inc;
        m_len   = TLW'(1);
      end else begin
        case (ch)
          CH_PLUS: begin
            cb.valid = 1'b1; cb.tok.kind = KIND_OP; cb.tok.symbol = SYM_ADD;
          end
          CH_MINUS: begin
            cb.valid = 1'b1; cb.tok.kind = KIND_OP; cb.tok.symbol = SYM_SUB;
          end
          CH_STAR: begin
            cb.valid = 1'b1; cb.tok.kind = KIND_OP; cb.tok.symbol = SYM_MUL;
          end
          CH_PERCENT: begin
            cb.valid = 1'b1; cb.tok.kind = KIND_OP; cb.tok.symbol = SYM_MOD;
          end
          CH_LPAREN: begin
            cb.valid = 1'b1; cb.tok.kind = KIND_PUNCT; cb.tok.symbol = SYM_LPAREN;
          end
          CH_RPAREN: begin
            cb.valid = 1'b1; cb.tok.kind = KIND_PUNCT; cb.tok.symbol = SYM_RPAREN;
          end
          CH_LBRACE: begin
            cb.valid = 1'b1; cb.tok.kind = KIND_PUNCT; cb.tok.symbol = SYM_LBRACE;
          end
          CH_RBRACE: begin
            cb.valid = 1'b1; cb.tok.kind = KIND_PUNCT; cb.tok.symbol = SYM_RBRACE;
          end
          CH_COMMA: begin
            cb.valid = 1'b1; cb.tok.kind = KIND_PUNCT; cb.tok.symbol = SYM_COMMA;
          end
          CH_SEMI: begin
            cb.valid = 1'b1; cb.tok.kind = KIND_PUNCT; cb.tok.symbol = SYM_SEMI;
          end
          CH_HASH: m_skip = 1'b1;
          default: cb.valid = 1'b0;
        endcase
      end
    end

    // End of text flushes what is left
    cc = end_of_text ? flush_tok(m_class, m_char, m_kw, m_len, m_start, m_line) : '0;
  end

  // Next state on a transfer
  always_comb begin
    pending_class_next = pending_class;
    pending_char_next  = pending_char;
    skip_to_eol_next   = skip_to_eol;
    line_count_next    = line_count;
    column_count_next  = column_count;
    token_start_next   = token_start;
    token_length_next  = token_length;
    keyword_match_next = keyword_match;
    if (accept) begin
      skip_to_eol_next  = m_skip;
      line_count_next   = m_line;
      column_count_next = m_col;
      token_start_next  = m_start;
      if (end_of_text) begin
        pending_class_next = PC_NONE;
        pending_char_next  = 8'd0;
        token_length_next  = '0;
        keyword_match_next = KW_NONE;
      end else begin
        pending_class_next = m_class;
        pending_char_next  = m_char;
        token_length_next  = m_len;
        keyword_match_next = m_kw;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_class <= PC_NONE;
      pending_char  <= 8'd0;
      skip_to_eol   <= 1'b0;
      line_count    <= LINE_BITS'(1);
      column_count  <= '0;
      token_start   <= '0;
      token_length  <= '0;
      keyword_match <= KW_NONE;
    end else begin
      pending_class <= pending_class_next;
      pending_char  <= pending_char_next;
      skip_to_eol   <= skip_to_eol_next;
      line_count    <= line_count_next;
      column_count  <= column_count_next;
      token_start   <= token_start_next;
      token_length  <= token_length_next;
      keyword_match <= keyword_match_next;
    end
  end

  // Pack the up to two results in emission order
  always_comb begin
    n_res = {1'b0, ca.valid} + {1'b0, cb.valid} + {1'b0, cc.valid};
    res0  = ca.valid ? ca.tok : (cb.valid ? cb.tok : cc.tok);
    res1  = (ca.valid && cb.valid) ? cb.tok : cc.tok;
    res0.last_of_run = (n_res == 2'd1);
    res1.last_of_run = 1'b1;
  end

endmodule

/* hw/rtl/sct_outq.sv */
`timescale 1ns / 1ps

module sct_outq (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [1:0]    push_n,
  input  sct_pkg::tok_t d0,
  input  sct_pkg::tok_t d1,
  output logic          space,
  input  logic          pop,
  output logic          q_valid,
  output sct_pkg::tok_t q
);

  import sct_pkg::*;

  localparam int PW = $clog2(OQ_DEPTH);
  localparam int CW = PW + 1;

  tok_t          entries [OQ_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [PW-1:0] wr_ptr_p1;
  logic [CW-1:0] count;
  logic [1:0]    n_push;
  logic          do_pop;

  assign n_push    = push ? push_n : 2'd0;
  assign do_pop    = q_valid && pop;
  assign wr_ptr_p1 = PW'(wr_ptr + 1'b1);

  // Room for a whole byte's worth of results
  assign space   = (count <= CW'(OQ_DEPTH - 2));
  assign q_valid = (count != '0);
  assign q       = entries[rd_ptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= PW'(wr_ptr + PW'(n_push));
      rd_ptr <= PW'(rd_ptr + PW'(do_pop));
      count  <= CW'(count + CW'(n_push) - CW'(do_pop));
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      entries[wr_ptr] <= d0;
    end
    if (n_push == 2'd2) begin
      entries[wr_ptr_p1] <= d1;
    end
  end

endmodule

/* hw/rtl/source_char_tokenizer.sv */
// A token caused by an accepted byte is decoded combinationally and registered into the result
// queue on the transfer. One byte per cycle while the result queue has room; a byte that yields
// two tokens presents them on the single output port one after the other, buffered in a
// four-entry result queue that takes a byte whenever it holds two entries or fewer.
// Reset (synchronous, active high): no token pending, line 1, column 0, result queue empty.
`timescale 1ns / 1ps

`include "source_char_tokenizer_macros.svh"

module source_char_tokenizer #(
  parameter int MAX_TOKEN_LEN = sct_pkg::MAX_TOKEN_LEN_DEF,
  parameter int LINE_BITS     = sct_pkg::LINE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  ch,
  input  logic        end_of_text,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  kind,
  output logic [4:0]  symbol,
  output logic [15:0] line,
  output logic [15:0] column,
  output logic [7:0]  length,
  output logic        last_of_run
);

  import sct_pkg::*;

  logic       in_fire;
  logic [1:0] n_res;
  tok_t       res0, res1;
  tok_t       q;

  assign in_fire = in_valid && in_ready;

  // Byte decode and tokenizer state
  sct_core #(
    .MAX_TOKEN_LEN (MAX_TOKEN_LEN),
    .LINE_BITS     (LINE_BITS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .accept      (in_fire),
    .ch          (ch),
    .end_of_text (end_of_text),
    .n_res       (n_res),
    .res0        (res0),
    .res1        (res1)
  );

  // Result buffering
  sct_outq u_outq (
    .clk     (clk),
    .rst     (rst),
    .push    (in_fire),
    .push_n  (n_res),
    .d0      (res0),
    .d1      (res1),
    .space   (in_ready),
    .pop     (out_ready),
    .q_valid (out_valid),
    .q       (q)
  );

  assign kind        = q.kind;
  assign symbol      = q.symbol;
  assign line        = q.line;
  assign column      = q.column;
  assign length      = q.length;
  assign last_of_run = q.last_of_run;

  // Checks
  `SCT_ASSERT(a_max_two, n_res != 2'd3, "more than two tokens for one byte")
  `SCT_ASSERT(a_res_shown, in_fire && n_res != 2'd0 |=> out_valid, "token not presented")
  `SCT_ASSERT_RST(a_rst_empty, rst |=> !out_valid, "result queue not empty after reset")

endmodule

/* tb/source_char_tokenizer_tb.sv */
`timescale 1ns / 1ps

module source_char_tokenizer_tb;
  import sct_pkg::*;

  localparam logic [15:0] COUNT_TOP = 16'hFFFF;
  localparam logic [7:0]  LEN_TOP   = 8'd255;
  localparam int          RANDOM_BYTES = 580;

  // One directed byte; tok holds the typed-in token where typed is set
  typedef struct packed {
    logic [7:0] c;
    logic       eot;
    logic       typed;
    tok_t       tok;
  } script_row_t;

  localparam tok_t NO_TOK = '0;

  localparam script_row_t SCRIPT [0:45] = '{
    // line 1: every operator, and every punctuator but the left paren
    '{CH_PLUS,   1'b0, 1'b1, '{KIND_OP, SYM_ADD, 16'd1, 16'd1, 8'd1, 1'b1}},
    '{CH_SEMI,   1'b0, 1'b1, '{KIND_PUNCT, SYM_SEMI, 16'd1, 16'd2, 8'd1, 1'b1}},
    '{CH_MINUS,  1'b0, 1'b0, NO_TOK},
    '{CH_STAR,   1'b0, 1'b0, NO_TOK},
    '{CH_PERCENT, 1'b0, 1'b0, NO_TOK},
    '{CH_RPAREN, 1'b0, 1'b0, NO_TOK},
    '{CH_LBRACE, 1'b0, 1'b0, NO_TOK},
    '{CH_RBRACE, 1'b0, 1'b0, NO_TOK},
    '{CH_COMMA,  1'b0, 1'b0, NO_TOK},
    '{CH_EQ,     1'b0, 1'b0, NO_TOK},
    '{CH_EQ,     1'b0, 1'b0, NO_TOK},
    '{CH_BANG,   1'b0, 1'b0, NO_TOK},
    '{CH_EQ,     1'b0, 1'b0, NO_TOK},
    '{CH_LT,     1'b0, 1'b0, NO_TOK},
    '{CH_EQ,     1'b0, 1'b0, NO_TOK},
    '{CH_GT,     1'b0, 1'b0, NO_TOK},
    '{CH_EQ,     1'b0, 1'b0, NO_TOK},
    '{CH_LT,     1'b0, 1'b0, NO_TOK},
    '{CH_GT,     1'b0, 1'b0, NO_TOK},
    '{CH_SLASH,  1'b0, 1'b0, NO_TOK},
    '{CH_EQ,     1'b0, 1'b0, NO_TOK},
    '{CH_BANG,   1'b0, 1'b0, NO_TOK},
    '{".",       1'b0, 1'b0, NO_TOK},
    '{CH_NL,     1'b0, 1'b0, NO_TOK},
    // line 2: keyword ended by a punctuator, digits then letters, hash comment
    '{"i",       1'b0, 1'b0, NO_TOK},
    '{"f",       1'b0, 1'b0, NO_TOK},
    '{CH_LPAREN, 1'b0, 1'b0, NO_TOK},
    '{"1",       1'b0, 1'b0, NO_TOK},
    '{"2",       1'b0, 1'b0, NO_TOK},
    '{"a",       1'b0, 1'b0, NO_TOK},
    '{"b",       1'b0, 1'b0, NO_TOK},
    '{CH_HASH,   1'b0, 1'b0, NO_TOK},
    '{8'hFF,     1'b0, 1'b0, NO_TOK},
    '{CH_NL,     1'b0, 1'b0, NO_TOK},
    // line 3: keyword ended by a slash comment
    '{"e",       1'b0, 1'b0, NO_TOK},
    '{"l",       1'b0, 1'b0, NO_TOK},
    '{"s",       1'b0, 1'b0, NO_TOK},
    '{"e",       1'b0, 1'b0, NO_TOK},
    '{CH_SLASH,  1'b0, 1'b0, NO_TOK},
    '{CH_SLASH,  1'b0, 1'b0, NO_TOK},
    '{8'h00,     1'b0, 1'b0, NO_TOK},
    '{CH_NL,     1'b0, 1'b0, NO_TOK},
    // line 4: keyword flushed by end of text
    '{"t",       1'b0, 1'b0, NO_TOK},
    '{"h",       1'b0, 1'b0, NO_TOK},
    '{"e",       1'b0, 1'b0, NO_TOK},
    '{"n",       1'b1, 1'b1, '{KIND_COND, 5'd0, 16'd4, 16'd1, 8'd4, 1'b1}}
  };

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  ch = 8'd0;
  logic        end_of_text = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  kind;
  logic [4:0]  symbol;
  logic [15:0] line;
  logic [15:0] column;
  logic [7:0]  length;
  logic        last_of_run;

  source_char_tokenizer dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .ch          (ch),
    .end_of_text (end_of_text),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .symbol      (symbol),
    .line        (line),
    .column      (column),
    .length      (length),
    .last_of_run (last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Tokens still owed by the block, oldest first
  tok_t        token_q[$];
  // Tokens caused by the byte just transferred
  tok_t        byte_toks[$];
  // Source text waiting to be sent
  logic [7:0]  text_q[$];
  int          errors = 0;
  int          bytes_sent = 0;
  bit          calm = 1'b0;
  bit          stall_req = 1'b0;

  // Lexer state mirror
  pend_class_t pend;
  logic [7:0]  pend_ch;
  bit          in_comment;
  logic [15:0] line_no;
  logic [15:0] col_no;
  logic [15:0] tok_col;
  logic [7:0]  tok_len;
  kw_t         kw;

  function automatic bit letter_byte(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic bit digit_byte(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic string spelling(kw_t k);
    case (k)
      KW_IF:   return "if";
      KW_THEN: return "then";
      KW_ELSE: return "else";
      default: return "";
    endcase
  endfunction

  function void emit_tok(logic [2:0] k, logic [4:0] s, logic [15:0] col, logic [7:0] len);
    tok_t t;
    t.kind        = k;
    t.symbol      = s;
    t.line        = line_no;
    t.column      = col;
    t.length      = len;
    t.last_of_run = 1'b0;
    byte_toks.insert(byte_toks.size(), t);
  endfunction

  // Emit whatever token is pending and clear it
  function void flush_pending();
    string w;
    case (pend)
      PC_IDENT: begin
        w = spelling(kw);
        if (kw != KW_NONE && tok_len == w.len())
          emit_tok(KIND_COND, 5'd0, tok_col, tok_len);
        else
          emit_tok(KIND_IDENT, 5'd0, tok_col, tok_len);
      end
      PC_NUMBER: emit_tok(KIND_INT, 5'd0, tok_col, tok_len);
      PC_PREFIX: begin
        case (pend_ch)
          CH_EQ:    emit_tok(KIND_OP, SYM_ASSIGN, tok_col, 8'd1);
          CH_LT:    emit_tok(KIND_OP, SYM_LT, tok_col, 8'd1);
          CH_GT:    emit_tok(KIND_OP, SYM_GT, tok_col, 8'd1);
          CH_SLASH: emit_tok(KIND_OP, SYM_DIV, tok_col, 8'd1);
          default: ; // lone bang gives nothing
        endcase
      end
      default: ;
    endcase
    pend    = PC_NONE;
    pend_ch = 8'd0;
    tok_len = 8'd0;
    kw      = KW_NONE;
  endfunction

  // A byte seen with nothing pending
  function void open_token(logic [7:0] c);
    if (letter_byte(c) || digit_byte(c) || c inside {CH_EQ, CH_LT, CH_GT, CH_BANG, CH_SLASH}) begin
      tok_col = col_no;
      tok_len = 8'd1;
      if (letter_byte(c)) begin
        pend = PC_IDENT;
        kw = (c == "i") ? KW_IF : (c == "t") ? KW_THEN : (c == "e") ? KW_ELSE : KW_NONE;
      end else if (digit_byte(c)) begin
        pend = PC_NUMBER;
      end else begin
        pend    = PC_PREFIX;
        pend_ch = c;
      end
    end else begin
      case (c)
        CH_PLUS:    emit_tok(KIND_OP, SYM_ADD, col_no, 8'd1);
        CH_MINUS:   emit_tok(KIND_OP, SYM_SUB, col_no, 8'd1);
        CH_STAR:    emit_tok(KIND_OP, SYM_MUL, col_no, 8'd1);
        CH_PERCENT: emit_tok(KIND_OP, SYM_MOD, col_no, 8'd1);
        CH_LPAREN:  emit_tok(KIND_PUNCT, SYM_LPAREN, col_no, 8'd1);
        CH_RPAREN:  emit_tok(KIND_PUNCT, SYM_RPAREN, col_no, 8'd1);
        CH_LBRACE:  emit_tok(KIND_PUNCT, SYM_LBRACE, col_no, 8'd1);
        CH_RBRACE:  emit_tok(KIND_PUNCT, SYM_RBRACE, col_no, 8'd1);
        CH_COMMA:   emit_tok(KIND_PUNCT, SYM_COMMA, col_no, 8'd1);
        CH_SEMI:    emit_tok(KIND_PUNCT, SYM_SEMI, col_no, 8'd1);
        CH_HASH:    in_comment = 1'b1;
        default: ; // skipped byte
      endcase
    end
  endfunction

  // Extend an identifier or number, dropping the keyword guess on a mismatch
  function void grow_token(logic [7:0] c);
    string w;
    if (kw != KW_NONE) begin
      w = spelling(kw);
      if (tok_len >= w.len() || w[tok_len] != c)
        kw = KW_NONE;
    end
    if (tok_len < LEN_TOP)
      tok_len++;
  endfunction

  // Tokens caused by one transferred byte, into byte_toks
  function void tokenize_byte(logic [7:0] c, logic eot);
    tok_t t;
    byte_toks.delete();
    if (c == CH_NL) begin
      flush_pending();
      in_comment = 1'b0;
      if (line_no != COUNT_TOP)
        line_no++;
      col_no = 16'd0;
    end else begin
      if (col_no != COUNT_TOP)
        col_no++;
      if (in_comment) begin
        // comment body
      end else if (pend == PC_PREFIX) begin
        if (c == CH_EQ && pend_ch inside {CH_EQ, CH_BANG, CH_LT, CH_GT}) begin
          case (pend_ch)
            CH_EQ:   emit_tok(KIND_OP, SYM_EQ, tok_col, 8'd2);
            CH_BANG: emit_tok(KIND_OP, SYM_NE, tok_col, 8'd2);
            CH_LT:   emit_tok(KIND_OP, SYM_LE, tok_col, 8'd2);
            default: emit_tok(KIND_OP, SYM_GE, tok_col, 8'd2);
          endcase
          pend    = PC_NONE;
          pend_ch = 8'd0;
          tok_len = 8'd0;
        end else if (c == CH_SLASH && pend_ch == CH_SLASH) begin
          pend       = PC_NONE;
          pend_ch    = 8'd0;
          tok_len    = 8'd0;
          in_comment = 1'b1;
        end else begin
          flush_pending();
          open_token(c);
        end
      end else if (pend == PC_IDENT && (letter_byte(c) || digit_byte(c))) begin
        grow_token(c);
      end else if (pend == PC_NUMBER && digit_byte(c)) begin
        grow_token(c);
      end else begin
        flush_pending();
        open_token(c);
      end
    end
    if (eot)
      flush_pending();
    if (byte_toks.size() > 0) begin
      t = byte_toks[byte_toks.size() - 1];
      t.last_of_run = 1'b1;
      byte_toks[byte_toks.size() - 1] = t;
    end
  endfunction

  // Offer one byte until the transfer, then book its tokens
  task automatic send_byte(input logic [7:0] c, input logic eot,
                           input bit typed = 1'b0, input tok_t typed_tok = '0);
    while (!calm && $urandom_range(0, 99) < 10) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    ch          <= c;
    end_of_text <= eot;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    tokenize_byte(c, eot);
    if (typed)
      token_q.insert(token_q.size(), typed_tok);
    else
      foreach (byte_toks[i]) token_q.insert(token_q.size(), byte_toks[i]);
  endtask

  function automatic logic [7:0] ident_byte(bit lead);
    int r;
    r = lead ? $urandom_range(0, 52) : $urandom_range(0, 62);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r == 52) return "_";
    return 8'("0" + r - 53);
  endfunction

  function automatic logic [7:0] non_nl_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    return (b == CH_NL) ? 8'h2E : b;
  endfunction

  function void push_word(string w);
    for (int i = 0; i < w.len(); i++)
      text_q.insert(text_q.size(), w[i]);
  endfunction

  function void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // Output side: compare every transfer with the oldest token owed
  always @(posedge clk) begin
    tok_t want;
    if (!rst && out_valid && out_ready) begin
      if (token_q.size() == 0) begin
        $display("%0t: unexpected token, expected none, actual kind %0d symbol %0d line %0d col %0d",
                 $time, kind, symbol, line, column);
        errors++;
      end else begin
        want = token_q.pop_front();
        check_field("kind", want.kind, kind);
        check_field("symbol", want.symbol, symbol);
        check_field("line", want.line, line);
        check_field("column", want.column, column);
        check_field("length", want.length, length);
        check_field("last_of_run", want.last_of_run, last_of_run);
      end
    end
  end

  // Receiver: random back-pressure, plus one long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    wait (!rst);
    forever begin
      @(posedge clk);
      if (stall_req) begin
        stall_req  = 1'b0;
        stall_left = 80;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(0, 99) >= 10);
      end
    end
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    string ops [13] = '{"+", "-", "*", "/", "%", "=", "==", "!=", "<=", ">=", "<", ">", "!"};
    string puncts;
    int    pick;
    bit    stall_done;

    puncts     = "(){},;";
    stall_done = 1'b0;
    pend       = PC_NONE;
    pend_ch    = 8'd0;
    in_comment = 1'b0;
    line_no    = 16'd1;
    col_no     = 16'd0;
    tok_col    = 16'd0;
    tok_len    = 8'd0;
    kw         = KW_NONE;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed script
    foreach (SCRIPT[i])
      send_byte(SCRIPT[i].c, SCRIPT[i].eot, SCRIPT[i].typed, SCRIPT[i].tok);

    // Random source text built from well-formed fragments plus noise
    while (bytes_sent < RANDOM_BYTES) begin
      if (!stall_done && bytes_sent >= 250) begin
        stall_req  = 1'b1;
        stall_done = 1'b1;
      end
      calm = (bytes_sent >= 380 && bytes_sent < 520);
      text_q.delete();
      pick = $urandom_range(0, 14);
      if (pick < 3) begin
        if ($urandom_range(0, 3) == 0) begin
          case ($urandom_range(0, 5))
            0: push_word("if");
            1: push_word("then");
            2: push_word("else");
            3: push_word("th");
            4: push_word("elsef");
            default: push_word("if_9");
          endcase
        end else begin
          text_q.insert(text_q.size(), ident_byte(1'b1));
          repeat ($urandom_range(0, 7)) text_q.insert(text_q.size(), ident_byte(1'b0));
        end
      end else if (pick < 5) begin
        repeat ($urandom_range(1, 5))
          text_q.insert(text_q.size(), 8'("0" + $urandom_range(0, 9)));
      end else if (pick < 8) begin
        push_word(ops[$urandom_range(0, 12)]);
      end else if (pick < 10) begin
        text_q.insert(text_q.size(), puncts[$urandom_range(0, 5)]);
      end else if (pick < 12) begin
        push_word($urandom_range(0, 1) ? " " : "\t");
      end else if (pick == 12) begin
        push_word($urandom_range(0, 1) ? "#" : "//");
        repeat ($urandom_range(0, 5)) text_q.insert(text_q.size(), non_nl_byte());
        text_q.insert(text_q.size(), CH_NL);
      end else if (pick == 13) begin
        text_q.insert(text_q.size(), CH_NL);
      end else begin
        text_q.insert(text_q.size(), 8'($urandom_range(0, 255)));
      end
      foreach (text_q[i])
        send_byte(text_q[i], $urandom_range(0, 49) == 0);
    end
    calm = 1'b0;

    // Identifier longer than the length counter
    send_byte(CH_NL, 1'b0);
    send_byte("z", 1'b0);
    repeat (259) send_byte(ident_byte(1'b0), 1'b0);
    send_byte(" ", 1'b0);

    // Operator, then an identifier flushed by end of text
    send_byte(CH_PLUS, 1'b0);
    send_byte("x", 1'b1);
    in_valid <= 1'b0;

    while (token_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
